// File: design/sbz_pkg.sv
// Shared types, constants and weight function for the sliding cubic Bezier sampler.
// Used by sbz_ctrl, sbz_datapath and sliding_cubic_bezier_sampler_top.
package sbz_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int STEPS          = 15;
	localparam int DENOM          = 3375;
	localparam int WEIGHT_W       = 12;
	localparam int T_W            = 4;
	localparam int NUM_CP         = 4;

	localparam logic [T_W-1:0] T_FIRST = 4'd0;
	localparam logic [T_W-1:0] T_LATE  = 4'd10;
	localparam logic [T_W-1:0] T_LAST  = 4'd15;

	typedef enum logic [1:0] {
		WIN_HOLD,
		WIN_INIT,
		WIN_PUSH_IN,
		WIN_PUSH_P
	} win_op_t;

	typedef struct packed {
		logic           load_p;
		win_op_t        win_op;
		logic           issue;
		logic           seg_b;
		logic [T_W-1:0] t;
		logic           run_last;
	} ctl_cmd_t;

	typedef struct packed {
		logic can_issue;
	} dp_stat_t;

	// Bernstein weight of control point idx at step t, scaled by STEPS^3
	function automatic logic [WEIGHT_W-1:0] sbz_weight(input logic [T_W-1:0] t,
		input logic [1:0] idx);
		int unsigned s;
		int unsigned k;
		int unsigned w;
		s = STEPS - int'(t);
		k = int'(t);
		unique case (idx)
			2'd0: w = s * s * s;
			2'd1: w = 3 * k * s * s;
			2'd2: w = 3 * k * k * s;
			2'd3: w = k * k * k;
			default: w = 0;
		endcase
		return w[WEIGHT_W-1:0];
	endfunction

endpackage

// File: design/sbz_ctrl.sv
// Sequencer for the sampler: tracks path position, steps t over each segment
// and commands the datapath. Depends on sbz_pkg.
module sbz_ctrl
	import sbz_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     path_end,
	output logic     in_ready,
	output ctl_cmd_t cmd,
	input  dp_stat_t stat
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEG_A,
		ST_SEG_B
	} state_t;

	typedef enum logic [1:0] {
		PS_NONE,
		PS_ONE,
		PS_MORE
	} seen_t;

	state_t         state_q;
	seen_t          seen_q;
	logic           first_q;
	logic           last_q;
	logic [T_W-1:0] t_q;
	logic           accept;
	logic           at_end;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign at_end   = (t_q == T_LAST);

	always_comb begin
		cmd          = '0;
		cmd.load_p   = accept;
		cmd.win_op   = WIN_HOLD;
		cmd.issue    = (state_q != ST_IDLE) && stat.can_issue;
		cmd.seg_b    = (state_q == ST_SEG_B);
		cmd.t        = t_q;
		cmd.run_last = at_end && ((state_q == ST_SEG_B) || !last_q);
		if (accept && !path_end) begin
			if (seen_q == PS_NONE)
				cmd.win_op = WIN_INIT;
			else if (seen_q == PS_ONE)
				cmd.win_op = WIN_PUSH_IN;
		end else if (state_q == ST_SEG_A && cmd.issue && at_end && !last_q) begin
			cmd.win_op = WIN_PUSH_P;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seen_q  <= PS_NONE;
			first_q <= 1'b0;
			last_q  <= 1'b0;
			t_q     <= T_FIRST;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (seen_q)
							PS_NONE: begin
								if (!path_end)
									seen_q <= PS_ONE;
							end
							PS_ONE: begin
								if (!path_end) begin
									seen_q <= PS_MORE;
								end else begin
									state_q <= ST_SEG_B;
									t_q     <= T_FIRST;
								end
							end
							PS_MORE: begin
								state_q <= ST_SEG_A;
								last_q  <= path_end;
								t_q     <= first_q ? T_LATE : T_FIRST;
							end
							default: seen_q <= PS_NONE;
						endcase
					end
				end
				ST_SEG_A: begin
					if (stat.can_issue) begin
						if (at_end) begin
							first_q <= 1'b1;
							if (last_q) begin
								state_q <= ST_SEG_B;
								t_q     <= T_LATE;
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							t_q <= t_q + 4'd1;
						end
					end
				end
				ST_SEG_B: begin
					if (stat.can_issue) begin
						if (at_end) begin
							state_q <= ST_IDLE;
							seen_q  <= PS_NONE;
							first_q <= 1'b0;
						end else begin
							t_q <= t_q + 4'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_path_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEG_B && stat.can_issue && at_end)
		|=> (seen_q == PS_NONE && !first_q && state_q == ST_IDLE))
		else $error("path state not cleared after closing segment");

	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue && cmd.run_last) |-> (t_q == T_LAST))
		else $error("run_last flagged before final step");

	a_late_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEG_B && seen_q == PS_MORE) |-> (t_q >= T_LATE))
		else $error("closing segment started below late step");

endmodule

// File: design/sbz_datapath.sv
// Window store, segment select and three-stage sample pipeline
// (weighted products, sum, reciprocal divide). Depends on sbz_pkg.
module sbz_datapath
	import sbz_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [COORD_BITS-1:0] point_x,
	input  logic [COORD_BITS-1:0] point_y,
	input  ctl_cmd_t              cmd,
	output dp_stat_t              stat,
	output logic [COORD_BITS:0]   sample_x,
	output logic [COORD_BITS:0]   sample_y,
	output logic                  run_last,
	output logic                  out_valid,
	input  logic                  out_ready
);

	localparam int PW    = COORD_BITS + 1;
	localparam int ACC_W = COORD_BITS + 13;
	localparam int RK    = ACC_W + WEIGHT_W;
	localparam int MW    = ACC_W + 1;
	localparam int QW    = ACC_W + MW;
	localparam logic [MW-1:0] RECIP_M =
		MW'(((64'd1 << RK) + 64'(DENOM) - 64'd1) / 64'(DENOM));

	logic [PW-1:0]    p_x_q, p_y_q;
	logic [PW-1:0]    w_x_q [3];
	logic [PW-1:0]    w_y_q [3];
	logic [PW-1:0]    cp_x [NUM_CP];
	logic [PW-1:0]    cp_y [NUM_CP];
	logic [ACC_W-1:0] prod_x [NUM_CP];
	logic [ACC_W-1:0] prod_y [NUM_CP];

	logic             v_s1, v_s2, v_s3;
	logic [ACC_W-1:0] prod_x_s1 [NUM_CP];
	logic [ACC_W-1:0] prod_y_s1 [NUM_CP];
	logic             last_s1, last_s2, last_s3;
	logic [ACC_W-1:0] acc_x_s2, acc_y_s2;
	logic [QW-1:0]    q_x, q_y;
	logic [PW-1:0]    sx_s3, sy_s3;
	logic             adv;

	assign adv            = !v_s3 || out_ready;
	assign stat.can_issue = adv;

	always_ff @(posedge clk) begin
		if (cmd.load_p) begin
			p_x_q <= PW'(point_x);
			p_y_q <= PW'(point_y);
		end
		unique case (cmd.win_op)
			WIN_HOLD: ;
			WIN_INIT: begin
				w_x_q[0] <= '0;
				w_y_q[0] <= '0;
				w_x_q[1] <= PW'(point_x) + PW'(1);
				w_y_q[1] <= PW'(point_y) + PW'(1);
				w_x_q[2] <= PW'(point_x);
				w_y_q[2] <= PW'(point_y);
			end
			WIN_PUSH_IN: begin
				w_x_q[0] <= w_x_q[1];
				w_y_q[0] <= w_y_q[1];
				w_x_q[1] <= w_x_q[2];
				w_y_q[1] <= w_y_q[2];
				w_x_q[2] <= PW'(point_x);
				w_y_q[2] <= PW'(point_y);
			end
			WIN_PUSH_P: begin
				w_x_q[0] <= w_x_q[1];
				w_y_q[0] <= w_y_q[1];
				w_x_q[1] <= w_x_q[2];
				w_y_q[1] <= w_y_q[2];
				w_x_q[2] <= p_x_q;
				w_y_q[2] <= p_y_q;
			end
			default: ;
		endcase
	end

	// select control points: opening window or closing window with end padding
	always_comb begin
		if (cmd.seg_b) begin
			cp_x[0] = w_x_q[1];
			cp_y[0] = w_y_q[1];
			cp_x[1] = w_x_q[2];
			cp_y[1] = w_y_q[2];
			cp_x[2] = p_x_q;
			cp_y[2] = p_y_q;
			cp_x[3] = w_x_q[2] + PW'(1);
			cp_y[3] = w_y_q[2] + PW'(1);
		end else begin
			cp_x[0] = w_x_q[0];
			cp_y[0] = w_y_q[0];
			cp_x[1] = w_x_q[1];
			cp_y[1] = w_y_q[1];
			cp_x[2] = w_x_q[2];
			cp_y[2] = w_y_q[2];
			cp_x[3] = p_x_q;
			cp_y[3] = p_y_q;
		end
		for (int i = 0; i < NUM_CP; i++) begin
			prod_x[i] = ACC_W'(cp_x[i]) * ACC_W'(sbz_weight(cmd.t, 2'(i)));
			prod_y[i] = ACC_W'(cp_y[i]) * ACC_W'(sbz_weight(cmd.t, 2'(i)));
		end
	end

	assign q_x = QW'(acc_x_s2) * QW'(RECIP_M);
	assign q_y = QW'(acc_y_s2) * QW'(RECIP_M);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_x_s1 <= prod_x;
			prod_y_s1 <= prod_y;
			last_s1   <= cmd.run_last;
			acc_x_s2  <= prod_x_s1[0] + prod_x_s1[1] + prod_x_s1[2] + prod_x_s1[3];
			acc_y_s2  <= prod_y_s1[0] + prod_y_s1[1] + prod_y_s1[2] + prod_y_s1[3];
			last_s2   <= last_s1;
			sx_s3     <= q_x[RK +: PW];
			sy_s3     <= q_y[RK +: PW];
			last_s3   <= last_s2;
		end
	end

	assign sample_x  = sx_s3;
	assign sample_y  = sy_s3;
	assign run_last  = last_s3;
	assign out_valid = v_s3;

	a_no_issue_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !out_ready) |-> !stat.can_issue)
		else $error("pipeline advanced under output stall");

	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (sample_x <= PW'(1 << COORD_BITS) && sample_y <= PW'(1 << COORD_BITS)))
		else $error("sample exceeds coordinate range");

	a_push_point: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.win_op == WIN_PUSH_P) |=> (w_x_q[2] == $past(p_x_q) && w_y_q[2] == $past(p_y_q)))
		else $error("held point not pushed into window");

endmodule

// File: design/sliding_cubic_bezier_sampler_top.sv
// Sliding cubic Bezier sampler. Path points arrive one item at a time, path_end on the final
// one; every window of four padded points is sampled as a cubic Bezier curve, 16 samples for
// the first window of a path and 6 (t = 10..15) for each later one, at one sample per cycle
// while the output is not stalled, from a three-stage pipeline (weighted products, sum,
// reciprocal divide by 3375). A point that produces no samples does not hold the input; a
// point that closes a window holds the input until its last sample has entered the pipeline,
// the final point of a path through its closing window too. Output stalls stop the pipeline
// and the sequencer together. Depends on sbz_pkg, sbz_ctrl and sbz_datapath.
module sliding_cubic_bezier_sampler_top
	import sbz_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] point_x,
	input  logic [COORD_BITS-1:0] point_y,
	input  logic                  path_end,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS:0]   sample_x,
	output logic [COORD_BITS:0]   sample_y,
	output logic                  run_last
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	sbz_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.path_end (path_end),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	sbz_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.point_x   (point_x),
		.point_y   (point_y),
		.cmd       (cmd),
		.stat      (stat),
		.sample_x  (sample_x),
		.sample_y  (sample_y),
		.run_last  (run_last),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule

// File: verif/sliding_cubic_bezier_sampler_top_tb.sv
// Testbench for sliding_cubic_bezier_sampler_top: sends paths of points and checks every
// curve sample against an in-bench predictor of the sliding Bezier windows.
// Depends on sbz_pkg and the sliding_cubic_bezier_sampler_top RTL.
module sliding_cubic_bezier_sampler_top_tb
	import sbz_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB         = COORD_BITS_DEF;
	localparam int QUIET_MAX  = 3000;
	localparam int HOLD_LEN   = 160;

	typedef struct {
		logic [CB:0] x;
		logic [CB:0] y;
		logic        last;
	} sample_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic [CB-1:0] point_x = '0;
	logic [CB-1:0] point_y = '0;
	logic          path_end = 1'b0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic [CB:0]   sample_x;
	logic [CB:0]   sample_y;
	logic          run_last;

	sample_t     expected_samples[$];
	sample_t     want_sample;
	logic [CB:0] path_win_x[3];
	logic [CB:0] path_win_y[3];
	int          path_points;
	bit          first_window_done;

	bit send_idle;
	bit recv_idle;
	bit hold_req;
	int mismatches;
	int samples_checked;
	int points_sent;
	int paths_sent;
	int quiet_cycles;

	sliding_cubic_bezier_sampler_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.point_x(point_x),
		.point_y(point_y),
		.path_end(path_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_x(sample_x),
		.sample_y(sample_y),
		.run_last(run_last)
	);

	always #5 clk = ~clk;

	function automatic void clear_path();
		for (int i = 0; i < 3; i++) begin
			path_win_x[i] = '0;
			path_win_y[i] = '0;
		end
		path_points = 0;
		first_window_done = 1'b0;
	endfunction

	function automatic void shift_window(input logic [CB:0] x, input logic [CB:0] y);
		path_win_x[0] = path_win_x[1];
		path_win_x[1] = path_win_x[2];
		path_win_x[2] = x;
		path_win_y[0] = path_win_y[1];
		path_win_y[1] = path_win_y[2];
		path_win_y[2] = y;
	endfunction

	function automatic logic [CB:0] curve_point(input int unsigned t, input logic [3:0][CB:0] p);
		longint unsigned s;
		longint unsigned k;
		longint unsigned a0;
		longint unsigned a1;
		longint unsigned a2;
		longint unsigned a3;
		longint unsigned q;
		s  = STEPS - t;
		k  = t;
		a0 = p[0];
		a1 = p[1];
		a2 = p[2];
		a3 = p[3];
		q  = (a0 * s * s * s + 3 * a1 * k * s * s + 3 * a2 * k * k * s + a3 * k * k * k) / DENOM;
		return q[CB:0];
	endfunction

	function automatic void emit_segment(input logic [3:0][CB:0] px, input logic [3:0][CB:0] py);
		int unsigned t0;
		sample_t     smp;
		t0 = first_window_done ? T_LATE : T_FIRST;
		for (int unsigned t = t0; t <= T_LAST; t++) begin
			smp.x    = curve_point(t, px);
			smp.y    = curve_point(t, py);
			smp.last = 1'b0;
			expected_samples.push_back(smp);
		end
		first_window_done = 1'b1;
	endfunction

	function automatic void predict_samples(input logic [CB-1:0] x, input logic [CB-1:0] y,
		input logic last);
		logic [3:0][CB:0] px;
		logic [3:0][CB:0] py;
		logic [CB:0]      xw;
		logic [CB:0]      yw;
		int               n0;
		xw = {1'b0, x};
		yw = {1'b0, y};
		n0 = expected_samples.size();
		if (path_points == 0) begin
			if (!last) begin
				shift_window(xw + 1'b1, yw + 1'b1);
				shift_window(xw, yw);
				path_points = 1;
			end else begin
				clear_path();
			end
			return;
		end
		if (path_points >= 2) begin
			px = {xw, path_win_x[2], path_win_x[1], path_win_x[0]};
			py = {yw, path_win_y[2], path_win_y[1], path_win_y[0]};
			emit_segment(px, py);
		end
		if (last) begin
			px = {path_win_x[2] + 1'b1, xw, path_win_x[2], path_win_x[1]};
			py = {path_win_y[2] + 1'b1, yw, path_win_y[2], path_win_y[1]};
			emit_segment(px, py);
			clear_path();
		end else begin
			shift_window(xw, yw);
			path_points = 2;
		end
		if (expected_samples.size() > n0)
			expected_samples[expected_samples.size() - 1].last = 1'b1;
	endfunction

	function automatic logic [CB-1:0] pick_coord();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		else if (r == 1)
			return '1;
		return CB'($urandom_range(0, (1 << CB) - 1));
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("mismatch on %s of sample %0d: got %0d, expected %0d", field, samples_checked,
			got, want);
		mismatches++;
	endtask

	task automatic send_point(input logic [CB-1:0] x, input logic [CB-1:0] y, input logic last);
		int gap;
		gap = 0;
		while (send_idle && $urandom_range(0, 99) < 25)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point_x  <= x;
		point_y  <= y;
		path_end <= last;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		predict_samples(x, y, last);
		points_sent++;
		if (last)
			paths_sent++;
	endtask

	task automatic send_path(input int len);
		for (int i = 0; i < len; i++)
			send_point(pick_coord(), pick_coord(), i == len - 1);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				report_mismatch("presence", 1, 0);
			end else begin
				want_sample = expected_samples.pop_front();
				if (sample_x !== want_sample.x)
					report_mismatch("sample_x", sample_x, want_sample.x);
				if (sample_y !== want_sample.y)
					report_mismatch("sample_y", sample_y, want_sample.y);
				if (run_last !== want_sample.last)
					report_mismatch("run_last", run_last, want_sample.last);
			end
			samples_checked++;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= recv_idle ? ($urandom_range(0, 99) >= 25) : 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_MAX) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic test_directed();
		send_idle = 1'b1;
		recv_idle = 1'b1;
		send_point(12'd5, 12'd7, 1'b1);
		send_point('0, '0, 1'b0);
		send_point('1, '1, 1'b1);
		send_point('1, '0, 1'b0);
		send_point('0, '1, 1'b0);
		send_point('1, '1, 1'b1);
		send_point('0, '0, 1'b0);
		send_point('0, '0, 1'b0);
		send_point('1, '1, 1'b0);
		send_point('1, '0, 1'b1);
		send_point('1, '1, 1'b0);
		send_point('1, '1, 1'b0);
		send_point('1, '1, 1'b1);
		send_point(12'hAAA, 12'h555, 1'b0);
		send_point(12'h555, 12'hAAA, 1'b1);
		send_point('0, '1, 1'b1);
		send_point(12'd100, 12'd200, 1'b0);
		send_point(12'd300, 12'd50, 1'b0);
		send_point(12'd4000, 12'd10, 1'b0);
		send_point(12'd7, 12'd3000, 1'b0);
		send_point(12'd2048, 12'd2047, 1'b1);
	endtask

	task automatic test_random_paths(input int n_points);
		int start;
		int r;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		start = points_sent;
		while (points_sent - start < n_points) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				send_path(1);
			else if (r < 20)
				send_path(2);
			else if (r < 90)
				send_path($urandom_range(3, 8));
			else
				send_path($urandom_range(9, 20));
		end
	endtask

	task automatic test_no_idle();
		send_idle = 1'b0;
		recv_idle = 1'b0;
		send_path(12);
		send_path(2);
		send_path(1);
		send_path(15);
	endtask

	task automatic test_output_stall();
		send_idle = 1'b0;
		recv_idle = 1'b0;
		hold_req  = 1'b1;
		send_path(18);
		send_idle = 1'b1;
		recv_idle = 1'b1;
		send_path(10);
	endtask

	initial begin
		clear_path();
		send_idle       = 1'b1;
		recv_idle       = 1'b1;
		hold_req        = 1'b0;
		mismatches      = 0;
		samples_checked = 0;
		points_sent     = 0;
		paths_sent      = 0;
		quiet_cycles    = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_paths(290);
		test_no_idle();
		test_output_stall();

		in_valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("sent %0d path points in %0d paths, checked %0d curve samples",
			points_sent, paths_sent, samples_checked);
		$display("covered one- and two-point paths, long paths, coordinate extremes, a long stall");
		if (mismatches == 0 && expected_samples.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
